// ===== rtl/bio_pkg.sv =====
// Shared widths and types of the box intersection over union pipeline.
package bio_pkg;

  localparam int unsigned FractionBits = 16;
  localparam int unsigned FieldW   = 16;
  localparam int unsigned CornerW  = FieldW + 3;
  localparam int unsigned GapW     = FieldW + 4;
  localparam int unsigned SpanW    = FieldW + 1;
  localparam int unsigned ProdW    = 2 * FieldW;
  localparam int unsigned InterW   = 2 * SpanW;
  localparam int unsigned UnionW   = ProdW + 3;
  localparam int unsigned RemW     = UnionW + 1;
  localparam int unsigned RatioW   = FractionBits + 1;
  localparam int unsigned InDataW  = 8 * FieldW;
  localparam int unsigned OutDataW = 24;

  // Members are listed from the highest bits down, so first_center_x, listed last, sits lowest.
  typedef struct packed {
    logic [FieldW-1:0] second_height;
    logic [FieldW-1:0] second_width;
    logic [FieldW-1:0] second_center_y;
    logic [FieldW-1:0] second_center_x;
    logic [FieldW-1:0] first_height;
    logic [FieldW-1:0] first_width;
    logic [FieldW-1:0] first_center_y;
    logic [FieldW-1:0] first_center_x;
  } box_pair_t;

endpackage

// ===== rtl/box_intersection_over_union_top.sv =====
// Top level of the box intersection over union pipeline.
//
//  Channel  Direction  Payload (lowest bits first)
//  s_axis   in         first cx, cy, w, h, second cx, cy, w, h (16 bits each)
//  m_axis   out        overlap_ratio (17 bits), zero padded to 24 bits
//
// One box pair is taken every cycle unless the output stalls; a result leaves after
// passing the three front stages and the chain of 17 divider cells.
// Each stage holds its own valid bit, so bubbles are absorbed and a stall backs up stage by stage.
// Reset clears only the valid bits; the pipeline is empty right after reset.
module box_intersection_over_union_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // first_center_x, first_center_y, first_width, first_height,
  // second_center_x, second_center_y, second_width, second_height
  input  logic [bio_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // overlap_ratio, then zero padding
  output logic [bio_pkg::OutDataW-1:0] m_axis_tdata
);
  import bio_pkg::*;

  localparam int unsigned QuoW = FractionBits + 1;

  logic              valid [QuoW+1];
  logic              ready [QuoW+1];
  logic [RemW-1:0]   rem   [QuoW+1];
  logic [UnionW-1:0] den   [QuoW+1];
  logic              zero  [QuoW+1];
  logic [QuoW-1:0]   quo   [QuoW+1];
  logic [RatioW-1:0] overlap_ratio;

  bio_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .boxes_i (box_pair_t'(s_axis_tdata)),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .rem_o   (rem[0]),
    .den_o   (den[0]),
    .zero_o  (zero[0])
  );

  assign quo[0] = '0;

  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    bio_div_cell #(
      .QuoW (QuoW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .ready_o (ready[i]),
      .rem_i   (rem[i]),
      .den_i   (den[i]),
      .zero_i  (zero[i]),
      .quo_i   (quo[i]),
      .valid_o (valid[i+1]),
      .ready_i (ready[i+1]),
      .rem_o   (rem[i+1]),
      .den_o   (den[i+1]),
      .zero_o  (zero[i+1]),
      .quo_o   (quo[i+1])
    );
  end

  assign ready[QuoW]   = m_axis_tready;
  assign m_axis_tvalid = valid[QuoW];
  assign overlap_ratio = RatioW'(quo[QuoW]);
  assign m_axis_tdata  = OutDataW'(overlap_ratio);

  a_empty_union_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid[QuoW] && zero[QuoW]) |-> (quo[QuoW] == '0))
    else $error("nonzero ratio for empty union");

  a_ratio_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[QuoW] |-> (quo[QuoW] <= {1'b1, {FractionBits{1'b0}}}))
    else $error("ratio above one");

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid && !valid[QuoW-1]) |=> !m_axis_tvalid)
    else $error("result appeared without an item behind it");

endmodule

// ===== rtl/bio_geom.sv =====
// Front stages: axis overlaps, the three area products and the union.
module bio_geom (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  bio_pkg::box_pair_t       boxes_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [bio_pkg::RemW-1:0] rem_o,
  output logic [bio_pkg::UnionW-1:0] den_o,
  output logic                     zero_o
);
  import bio_pkg::*;

  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_ready, b_ready, c_ready;

  logic [SpanW-1:0]  ox_d, oy_d, ox_q, oy_q;
  logic [FieldW-1:0] w1_q, h1_q, w2_q, h2_q;
  logic [InterW-1:0] inter_q;
  logic [ProdW-1:0]  area1_q, area2_q;
  logic [RemW-1:0]   rem_q;
  logic [UnionW-1:0] den_q;
  logic              zero_q;

  logic [ProdW:0]    total;
  logic [UnionW-1:0] total4;
  logic [UnionW-1:0] union4;

  function automatic logic [SpanW-1:0] span_overlap(
    input logic [FieldW-1:0] c1,
    input logic [FieldW-1:0] s1,
    input logic [FieldW-1:0] c2,
    input logic [FieldW-1:0] s2
  );
    logic signed [CornerW-1:0] lo1, hi1, lo2, hi2, lo_max, hi_min;
    logic signed [GapW-1:0]    gap;
    lo1 = $signed({2'b00, c1, 1'b0}) - $signed({3'b000, s1});
    hi1 = $signed({2'b00, c1, 1'b0}) + $signed({3'b000, s1});
    lo2 = $signed({2'b00, c2, 1'b0}) - $signed({3'b000, s2});
    hi2 = $signed({2'b00, c2, 1'b0}) + $signed({3'b000, s2});
    lo_max = (lo1 > lo2) ? lo1 : lo2;
    hi_min = (hi1 < hi2) ? hi1 : hi2;
    gap = GapW'(hi_min) - GapW'(lo_max);
    return (gap > 0) ? gap[SpanW-1:0] : '0;
  endfunction

  assign c_ready = !c_valid_q || ready_i;
  assign b_ready = !b_valid_q || c_ready;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  assign ox_d = span_overlap(boxes_i.first_center_x, boxes_i.first_width,
                             boxes_i.second_center_x, boxes_i.second_width);
  assign oy_d = span_overlap(boxes_i.first_center_y, boxes_i.first_height,
                             boxes_i.second_center_y, boxes_i.second_height);

  assign total  = {1'b0, area1_q} + {1'b0, area2_q};
  assign total4 = {total, 2'b00};
  assign union4 = total4 - UnionW'(inter_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && a_ready) begin
      ox_q <= ox_d;
      oy_q <= oy_d;
      w1_q <= boxes_i.first_width;
      h1_q <= boxes_i.first_height;
      w2_q <= boxes_i.second_width;
      h2_q <= boxes_i.second_height;
    end
    if (a_valid_q && b_ready) begin
      inter_q <= ox_q * oy_q;
      area1_q <= w1_q * h1_q;
      area2_q <= w2_q * h2_q;
    end
    if (b_valid_q && c_ready) begin
      rem_q  <= RemW'(inter_q);
      den_q  <= union4;
      zero_q <= (union4 == '0);
    end
  end

  assign valid_o = c_valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign zero_o  = zero_q;

  a_union_covers_inter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> ({1'b0, rem_q} <= {2'b00, den_q}))
    else $error("overlap area exceeds union");

  a_zero_means_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid_q && zero_q) |-> (rem_q == '0))
    else $error("empty union with nonzero overlap");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid_q && !ready_i) |=> (c_valid_q && $stable(den_q)))
    else $error("union stage changed while stalled");

endmodule

// ===== rtl/bio_div_cell.sv =====
// One cell of the divider chain: a compare and subtract that yields one quotient bit.
module bio_div_cell #(
  parameter int unsigned QuoW = 17
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [bio_pkg::RemW-1:0]   rem_i,
  input  logic [bio_pkg::UnionW-1:0] den_i,
  input  logic                       zero_i,
  input  logic [QuoW-1:0]            quo_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [bio_pkg::RemW-1:0]   rem_o,
  output logic [bio_pkg::UnionW-1:0] den_o,
  output logic                       zero_o,
  output logic [QuoW-1:0]            quo_o
);
  import bio_pkg::*;

  logic              valid_q;
  logic [RemW:0]     trial;
  logic              fits;
  logic [RemW-1:0]   part;
  logic [RemW-1:0]   rem_d, rem_q;
  logic [UnionW-1:0] den_q;
  logic              zero_q;
  logic [QuoW-1:0]   quo_d, quo_q;

  assign ready_o = !valid_q || ready_i;

  assign trial = {1'b0, rem_i} - {2'b00, den_i};
  assign fits  = !trial[RemW];
  assign part  = fits ? trial[RemW-1:0] : rem_i;
  assign rem_d = {part[RemW-2:0], 1'b0};
  assign quo_d = {quo_i[QuoW-2:0], fits && !zero_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      zero_q <= zero_i;
      quo_q  <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign zero_o  = zero_q;
  assign quo_o   = quo_q;

  a_rem_below_twice_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !zero_q) |-> (rem_q < {den_q, 1'b0}))
    else $error("partial remainder out of range");

  a_zero_gives_zero_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o && zero_i) |=> (quo_q[0] == 1'b0))
    else $error("quotient bit set for empty union");

  a_stall_keeps_quotient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> (valid_q && $stable(quo_q)))
    else $error("quotient changed while stalled");

endmodule
